### design/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expects clk and rst in scope; checks are disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/jsu_pkg.sv
// Shared types, constants and helpers for the JSON string unescape unit.
// No dependencies; imported by every module of the unit.
package jsu_pkg;

  localparam int RUN_MAX     = 6;
  localparam int RUN_CNT_W   = $clog2(RUN_MAX + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int HEX_SLOTS   = 3;

  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_BSL   = 8'h5C;
  localparam logic [7:0] CHR_SLASH = 8'h2F;
  localparam logic [7:0] CHR_B     = 8'h62;
  localparam logic [7:0] CHR_F     = 8'h66;
  localparam logic [7:0] CHR_N     = 8'h6E;
  localparam logic [7:0] CHR_R     = 8'h72;
  localparam logic [7:0] CHR_T     = 8'h74;
  localparam logic [7:0] CHR_U     = 8'h75;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_FF    = 8'h0C;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [7:0] CTL_TAB   = 8'h09;

  localparam logic [15:0] CP_ONE_LIMIT = 16'd128;
  localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
  localparam logic [2:0]  UTF8_LEAD2   = 3'b110;
  localparam logic [3:0]  UTF8_LEAD3   = 4'b1110;
  localparam logic [1:0]  UTF8_CONT    = 2'b10;

  typedef enum logic [5:0] {
    MODE_NORMAL = 6'b000001,
    MODE_ESC    = 6'b000010,
    MODE_HEX0   = 6'b000100,
    MODE_HEX1   = 6'b001000,
    MODE_HEX2   = 6'b010000,
    MODE_HEX3   = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } raw_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } text_item_t;

  // Bytes produced by one input item, in order from entry 0.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [RUN_CNT_W-1:0]    cnt;
  } run_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic full;
    logic nonempty;
  } queue_stat_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

endpackage

### design/json_string_unescape_unit.sv
// Top level of the JSON string unescape unit: front end, run queue, back end.
// Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back.
//
//   channel | handshake              | payload
//   raw     | raw_valid / raw_stall  | raw_item  (in_byte, end_of_string)
//   text    | text_valid / text_stall| text_item (out_byte, last_of_run)
//
// The front end takes one raw byte per cycle while the run queue has room.
// Each byte yields a run of 0 to 6 output bytes; the back end sends one byte per cycle
// while text_stall is low, so sustained input rate is one byte per cycle when runs
// average one byte or less. Runs go through the run queue, then the back end's register.
// Synchronous reset returns to plain text mode and empties the queue.
// raw_stall rises only when the four-entry run queue is full.
module json_string_unescape_unit import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       raw_valid,
  output logic       raw_stall,
  input  raw_item_t  raw_item,
  output logic       text_valid,
  input  logic       text_stall,
  output text_item_t text_item
);

  queue_stat_t qstat;
  logic        push, pop;
  run_t        push_run, head_run;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .raw_valid (raw_valid),
    .raw_item  (raw_item),
    .qstat     (qstat),
    .raw_stall (raw_stall),
    .push      (push),
    .push_run  (push_run)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head_run (head_run),
    .qstat    (qstat)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .head_run   (head_run),
    .pop        (pop),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_item  (text_item)
  );

endmodule

### design/jsu_front.sv
// Front end: accepts raw bytes, tracks escape state, builds one run of output bytes.
// Depends on jsu_pkg.
module jsu_front import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        raw_valid,
  input  raw_item_t   raw_item,
  input  queue_stat_t qstat,
  output logic        raw_stall,
  output logic        push,
  output run_t        push_run
);

  mode_t       mode, mode_next;
  logic [11:0] acc, acc_next;
  logic [HEX_SLOTS-1:0][7:0] store;
  logic [HEX_SLOTS-1:0] store_we;
  logic        accept;
  logic [7:0]  b;
  logic        eos;
  logic [4:0]  hx;
  logic [1:0]  k;
  logic        do_plain;
  logic [15:0] cp;
  run_t        run;

  assign b         = raw_item.in_byte;
  assign eos       = raw_item.end_of_string;
  assign hx        = hex_decode(b);
  assign cp        = {acc, hx[3:0]};
  assign raw_stall = qstat.full;
  assign accept    = raw_valid && !qstat.full;
  assign push      = accept && (run.cnt != '0);
  assign push_run  = run;

  always_comb begin
    unique case (mode) inside
      MODE_HEX1: k = 2'd1;
      MODE_HEX2: k = 2'd2;
      MODE_HEX3: k = 2'd3;
      default:   k = 2'd0;
    endcase
  end

  always_comb begin
    run      = '0;
    mode_next = MODE_NORMAL;
    acc_next = acc;
    store_we = '0;
    do_plain = 1'b0;
    unique case (mode) inside
      MODE_ESC: begin
        run.cnt = RUN_CNT_W'(1);
        case (b)
          CHR_QUOTE: run.bytes[0] = CHR_QUOTE;
          CHR_BSL:   run.bytes[0] = CHR_BSL;
          CHR_SLASH: run.bytes[0] = CHR_SLASH;
          CHR_B:     run.bytes[0] = CTL_BS;
          CHR_F:     run.bytes[0] = CTL_FF;
          CHR_N:     run.bytes[0] = CTL_LF;
          CHR_R:     run.bytes[0] = CTL_CR;
          CHR_T:     run.bytes[0] = CTL_TAB;
          CHR_U: begin
            if (eos) begin
              run.bytes[0] = CHR_BSL;
              run.bytes[1] = CHR_U;
              run.cnt      = RUN_CNT_W'(2);
            end else begin
              run.cnt   = '0;
              mode_next = MODE_HEX0;
              acc_next  = '0;
            end
          end
          default: begin
            // unknown escape: keep the backslash, then treat byte as text
            run.bytes[0] = CHR_BSL;
            do_plain     = 1'b1;
          end
        endcase
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        if (hx[4] && mode == MODE_HEX3) begin
          if (cp < CP_ONE_LIMIT) begin
            run.bytes[0] = cp[7:0];
            run.cnt      = RUN_CNT_W'(1);
          end else if (cp < CP_TWO_LIMIT) begin
            run.bytes[0] = {UTF8_LEAD2, cp[10:6]};
            run.bytes[1] = {UTF8_CONT, cp[5:0]};
            run.cnt      = RUN_CNT_W'(2);
          end else begin
            run.bytes[0] = {UTF8_LEAD3, cp[15:12]};
            run.bytes[1] = {UTF8_CONT, cp[11:6]};
            run.bytes[2] = {UTF8_CONT, cp[5:0]};
            run.cnt      = RUN_CNT_W'(3);
          end
        end else if (hx[4] && !eos) begin
          store_we[k] = 1'b1;
          acc_next    = {acc[7:0], hx[3:0]};
          unique case (mode) inside
            MODE_HEX0: mode_next = MODE_HEX1;
            MODE_HEX1: mode_next = MODE_HEX2;
            default:   mode_next = MODE_HEX3;
          endcase
        end else begin
          // flush the partial escape, then treat byte as text
          run.bytes[0] = CHR_BSL;
          run.bytes[1] = CHR_U;
          run.bytes[2] = store[0];
          run.bytes[3] = store[1];
          run.bytes[4] = store[2];
          run.cnt      = RUN_CNT_W'(2) + RUN_CNT_W'(k);
          do_plain     = 1'b1;
        end
      end
      default: do_plain = 1'b1;
    endcase
    if (do_plain) begin
      if (b == CHR_BSL && !eos) begin
        mode_next = MODE_ESC;
      end else begin
        run.bytes[run.cnt] = b;
        run.cnt            = run.cnt + RUN_CNT_W'(1);
      end
    end
    if (eos) begin
      mode_next = MODE_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      acc  <= '0;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HEX_SLOTS; i++) begin
      if (accept && store_we[i]) begin
        store[i] <= b;
      end
    end
  end

endmodule

### design/jsu_queue.sv
// Short run queue between front and back ends.
// Depends on jsu_pkg.
module jsu_queue import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  run_t        push_run,
  input  logic        pop,
  output run_t        head_run,
  output queue_stat_t qstat
);

  run_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                 do_push, do_pop;

  assign qstat.full     = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign qstat.nonempty = (count != '0);
  assign do_push        = push && !qstat.full;
  assign do_pop         = pop && qstat.nonempty;
  assign head_run       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      if (do_push && !do_pop) count <= count + QUEUE_CNT_W'(1);
      else if (do_pop && !do_push) count <= count - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_run;
    end
  end

endmodule

### design/jsu_back.sv
// Back end: holds one run and sends its bytes out one per cycle while text_stall is low.
// Depends on jsu_pkg.
module jsu_back import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  queue_stat_t qstat,
  input  run_t        head_run,
  output logic        pop,
  output logic        text_valid,
  input  logic        text_stall,
  output text_item_t  text_item
);

  run_t                 cur;
  logic [RUN_CNT_W-1:0] pos;
  logic                 busy;
  logic                 take, last;

  assign last       = (pos == cur.cnt - RUN_CNT_W'(1));
  assign take       = busy && !text_stall;
  assign pop        = qstat.nonempty && (!busy || (take && last));
  assign text_valid = busy;
  assign text_item  = '{out_byte: cur.bytes[pos], last_of_run: last};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      pos  <= '0;
    end else if (take && last) begin
      busy <= 1'b0;
    end else if (take) begin
      pos <= pos + RUN_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_run;
    end
  end

endmodule

### design/jsu_checker.sv
// Port-level checks for the JSON string unescape unit, bound to the top level.
// Depends on jsu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jsu_checker import jsu_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       raw_valid,
  input logic       raw_stall,
  input raw_item_t  raw_item,
  input logic       text_valid,
  input logic       text_stall,
  input text_item_t text_item
);

  logic raw_wait;
  logic text_wait;
  logic text_take;

  assign raw_wait  = raw_valid && raw_stall;
  assign text_wait = text_valid && text_stall;
  assign text_take = text_valid && !text_stall;

  `JSU_ASSERT_NEXT(a_raw_item_holds, raw_wait, raw_valid && $stable(raw_item), "raw item moved")
  `JSU_ASSERT_NEXT(a_text_valid_holds, text_wait, text_valid, "text valid dropped while stalled")
  `JSU_ASSERT_NEXT(a_text_item_holds, text_wait, $stable(text_item), "text item moved while stalled")
  `JSU_ASSERT_NEXT(a_run_continues, text_take && !text_item.last_of_run, text_valid, "run broken")
  `JSU_ASSERT_NOW(a_full_means_busy, raw_stall, text_valid, "input stalled with no output pending")

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst        (rst),
  .raw_valid  (raw_valid),
  .raw_stall  (raw_stall),
  .raw_item   (raw_item),
  .text_valid (text_valid),
  .text_stall (text_stall),
  .text_item  (text_item)
);

### verif/tb_json_string_unescape_unit.sv
// Self-checking testbench for json_string_unescape_unit: escape decoding and UTF-8 output.
// Depends on jsu_pkg and the unit RTL; drives raw bytes and checks every text item.
module tb_json_string_unescape_unit;
  import jsu_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_BYTES = 300;

  // Tracks the unescape state and holds the text items still owed by the unit.
  class unescape_tracker;
    mode_t       mode;
    logic [7:0]  hex_digits[HEX_SLOTS];
    logic [11:0] code_acc;
    logic [7:0]  run_bytes[$];
    text_item_t  owed_text[$];
    int          errors;
    int          bytes_in;
    int          bytes_checked;

    function new();
      mode = MODE_NORMAL;
      code_acc = '0;
      foreach (hex_digits[i]) hex_digits[i] = '0;
      errors = 0;
      bytes_in = 0;
      bytes_checked = 0;
    endfunction

    function void add_byte(logic [7:0] b);
      run_bytes.insert(run_bytes.size(), b);
    endfunction

    function int digit_value(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - int'("0");
      if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
      if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
      return -1;
    endfunction

    function void take_plain(logic [7:0] b, logic eos);
      if (b == CHR_BSL && !eos) mode = MODE_ESC;
      else add_byte(b);
    endfunction

    function void note_raw(raw_item_t it);
      logic [7:0]  b;
      logic        eos;
      int          v;
      int          k;
      logic [15:0] cp;
      text_item_t  t;
      b = it.in_byte;
      eos = it.end_of_string;
      run_bytes.delete();
      bytes_in++;
      case (mode)
        MODE_ESC: begin
          mode = MODE_NORMAL;
          case (b)
            CHR_QUOTE, CHR_BSL, CHR_SLASH: add_byte(b);
            CHR_B: add_byte(CTL_BS);
            CHR_F: add_byte(CTL_FF);
            CHR_N: add_byte(CTL_LF);
            CHR_R: add_byte(CTL_CR);
            CHR_T: add_byte(CTL_TAB);
            CHR_U: begin
              if (eos) begin
                add_byte(CHR_BSL);
                add_byte(CHR_U);
              end else begin
                mode = MODE_HEX0;
                code_acc = '0;
              end
            end
            default: begin
              add_byte(CHR_BSL);
              take_plain(b, eos);
            end
          endcase
        end
        MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
          k = (mode == MODE_HEX1) ? 1 : (mode == MODE_HEX2) ? 2 :
              (mode == MODE_HEX3) ? 3 : 0;
          v = digit_value(b);
          if (v >= 0 && k == 3) begin
            cp = {code_acc, 4'(v)};
            if (cp < CP_ONE_LIMIT) begin
              add_byte(cp[7:0]);
            end else if (cp < CP_TWO_LIMIT) begin
              add_byte({UTF8_LEAD2, cp[10:6]});
              add_byte({UTF8_CONT, cp[5:0]});
            end else begin
              add_byte({UTF8_LEAD3, cp[15:12]});
              add_byte({UTF8_CONT, cp[11:6]});
              add_byte({UTF8_CONT, cp[5:0]});
            end
            mode = MODE_NORMAL;
          end else if (v >= 0 && !eos) begin
            hex_digits[k] = b;
            code_acc = {code_acc[7:0], 4'(v)};
            mode = (k == 0) ? MODE_HEX1 : (k == 1) ? MODE_HEX2 : MODE_HEX3;
          end else begin
            // flush the partial escape, then treat the byte as text
            add_byte(CHR_BSL);
            add_byte(CHR_U);
            for (int j = 0; j < k; j++) add_byte(hex_digits[j]);
            mode = MODE_NORMAL;
            take_plain(b, eos);
          end
        end
        default: begin
          mode = MODE_NORMAL;
          take_plain(b, eos);
        end
      endcase
      if (eos) mode = MODE_NORMAL;
      foreach (run_bytes[i]) begin
        t.out_byte = run_bytes[i];
        t.last_of_run = (i == run_bytes.size() - 1);
        owed_text.insert(owed_text.size(), t);
      end
    endfunction

    function void check_text(text_item_t got);
      text_item_t want;
      bytes_checked++;
      if (owed_text.size() == 0) begin
        $display("%0t: unexpected text item: expected none, actual byte=%h last=%b",
                 $time, got.out_byte, got.last_of_run);
        errors++;
        return;
      end
      want = owed_text.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte mismatch: expected %h, actual %h",
                 $time, want.out_byte, got.out_byte);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run mismatch: expected %b, actual %b (byte %h)",
                 $time, want.last_of_run, got.last_of_run, want.out_byte);
        errors++;
      end
    endfunction

    function int owed();
      return owed_text.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       raw_valid;
  logic       raw_stall;
  raw_item_t  raw_item;
  logic       text_valid;
  logic       text_stall;
  text_item_t text_item;

  unescape_tracker sb;
  int          burst_left;
  int          idle_cycles;
  int          stall_left;
  logic [15:0] stall_pat;

  json_string_unescape_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .raw_valid  (raw_valid),
    .raw_stall  (raw_stall),
    .raw_item   (raw_item),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_item  (text_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stall: each window holds no stall, sparse stall or dense stall.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(16, 64);
      case ($urandom_range(0, 2))
        0: stall_pat <= '0;
        1: stall_pat <= 16'($urandom & $urandom);
        default: stall_pat <= 16'($urandom | $urandom);
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
    text_stall <= stall_pat[stall_left[3:0]];
  end

  always @(posedge clk) begin
    if (!rst && text_valid && !text_stall) sb.check_text(text_item);
  end

  always @(posedge clk) begin
    if (rst || (raw_valid && !raw_stall) || (text_valid && !text_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_raw(input logic [7:0] b, input logic eos);
    raw_item_t it;
    int gap;
    it.in_byte = b;
    it.end_of_string = eos;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        raw_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    raw_item = it;
    raw_valid = 1'b1;
    @(posedge clk);
    while (raw_stall) @(posedge clk);
    sb.note_raw(it);
    burst_left--;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_raw(s[i], i == s.len() - 1);
  endtask

  // Hold the sender off until the unit has delivered everything owed.
  task automatic drain();
    @(negedge clk);
    raw_valid = 1'b0;
    while (sb.owed() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return 8'("0" + v);
    return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  function automatic logic rare_end(int odds);
    return $urandom_range(0, odds - 1) == 0;
  endfunction

  task automatic random_sequence();
    logic [7:0] esc_chars[8];
    int         digits[4];
    int         kind;
    int         n;
    esc_chars = '{CHR_QUOTE, CHR_BSL, CHR_SLASH, CHR_B, CHR_F, CHR_N, CHR_R, CHR_T};
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      send_raw(8'($urandom_range(0, 255)), rare_end(8));
    end else if (kind < 45) begin
      send_raw(CHR_BSL, rare_end(30));
      send_raw(esc_chars[$urandom_range(0, 7)], rare_end(8));
    end else if (kind < 55) begin
      send_raw(CHR_BSL, rare_end(30));
      send_raw(8'($urandom_range(0, 255)), rare_end(6));
    end else if (kind < 85) begin
      // aim at each UTF-8 length
      case ($urandom_range(0, 2))
        0: digits = '{0, 0, $urandom_range(0, 7), $urandom_range(0, 15)};
        1: digits = '{0, $urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 15)};
        default: digits = '{$urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 15)};
      endcase
      send_raw(CHR_BSL, rare_end(40));
      send_raw(CHR_U, rare_end(40));
      for (int i = 0; i < 4; i++) begin
        send_raw(hex_char(digits[i]), i == 3 ? rare_end(8) : rare_end(40));
      end
    end else begin
      n = $urandom_range(0, 3);
      send_raw(CHR_BSL, 1'b0);
      send_raw(CHR_U, 1'b0);
      for (int i = 0; i < n; i++) send_raw(hex_char($urandom_range(0, 15)), 1'b0);
      if ($urandom_range(0, 3) == 0) send_raw(CHR_BSL, rare_end(3));
      else send_raw(8'($urandom_range(0, 255)), rare_end(3));
    end
  endtask

  initial begin
    bit paused;
    rst = 1'b1;
    raw_valid = 1'b0;
    raw_item = '0;
    text_stall = 1'b0;
    stall_left = 0;
    stall_pat = '0;
    burst_left = 0;
    idle_cycles = 0;
    paused = 1'b0;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: byte extremes, escapes, a three-byte unicode escape, truncations
    send_raw(8'h00, 1'b1);
    send_raw(8'hFF, 1'b0);
    send_raw(CHR_BSL, 1'b1);
    send_string("\\n\\t\\\"");
    send_string("\\q");
    send_string("\\u");
    send_string("\\u7fF");
    send_string("\\u1\\n");
    send_string("\\uD800");
    drain();

    while (sb.bytes_in < RANDOM_BYTES + 29) begin
      random_sequence();
      if (!paused && sb.bytes_in > 180) begin
        paused = 1'b1;
        drain();
      end
    end

    @(negedge clk);
    raw_valid = 1'b0;
    while (sb.owed() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d raw bytes (escapes, unicode, truncated and broken sequences),",
             sb.bytes_in);
    $display("checked %0d text items under random sender gaps and receiver stalls",
             sb.bytes_checked);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
